### hdl/deauth_frame_flow_table_core_macros.svh
// Assertion helpers for the checker.
`ifndef DEAUTH_FRAME_FLOW_TABLE_CORE_MACROS_SVH
`define DEAUTH_FRAME_FLOW_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define DFFT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define DFFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dfft_pkg.sv
package dfft_pkg;

    typedef struct packed {
        logic        is_mgmt;
        logic [15:0] ctrl_word;
        logic [11:0] frame_len;
        logic [47:0] dest_addr;
        logic [47:0] src_addr;
        logic [7:0]  reason_byte;
        logic [3:0]  channel;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic        frame_kind;
        logic [15:0] hit_count;
        logic [5:0]  entries_used;
    } out_item_t;

    typedef struct packed {
        logic [47:0] src;
        logic [47:0] dst;
        logic [3:0]  chan;
        logic        kind;
        logic [7:0]  reason;
        logic [31:0] seen;
        logic [15:0] hits;
    } entry_t;

    typedef struct packed {
        logic        match;
        logic        kind;
        logic [15:0] hits;
    } cmp_res_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [11:0] MIN_FRAME_LEN = 12'd26;
    localparam logic [1:0]  FTYPE_MGMT    = 2'h0;
    localparam logic [3:0]  SUB_DEAUTH    = 4'hC;
    localparam logic [3:0]  SUB_DISASSOC  = 4'hA;
    localparam logic [15:0] HITS_MAX      = 16'hFFFF;
    localparam logic [15:0] HITS_FIRST    = 16'd1;

    localparam logic [1:0] STATUS_IGNORED  = 2'd0;
    localparam logic [1:0] STATUS_UPDATED  = 2'd1;
    localparam logic [1:0] STATUS_NEW      = 2'd2;
    localparam logic [1:0] STATUS_REPLACED = 2'd3;

    localparam logic KIND_DEAUTH   = 1'b0;
    localparam logic KIND_DISASSOC = 1'b1;

endpackage

### hdl/dfft_ram.sv
module dfft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/dfft_cmp.sv
module dfft_cmp import dfft_pkg::*; #(
    parameter int IDX_W = 5
) (
    input  logic             aclk,
    input  logic             cmp_valid,
    input  logic [IDX_W-1:0] cmp_idx,
    input  entry_t           entry,
    input  in_item_t         key,
    output cmp_res_t         res,
    output logic [IDX_W-1:0] min_idx
);

    logic [31:0]      min_seen_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic             take_min;

    // key match on (src, dst, channel)
    assign res.match = cmp_valid && (entry.src == key.src_addr) &&
                       (entry.dst == key.dest_addr) && (entry.chan == key.channel);
    assign res.kind  = entry.kind;
    assign res.hits  = entry.hits;

    // strict less-than keeps the lowest index on ties; index 0 seeds the search
    assign take_min = cmp_valid && ((cmp_idx == '0) || (entry.seen < min_seen_reg));

    always_ff @(posedge aclk) begin
        if (take_min) begin
            min_seen_reg <= entry.seen;
            min_idx_reg  <= cmp_idx;
        end
    end

    assign min_idx = min_idx_reg;

endmodule

### hdl/deauth_frame_flow_table_core.sv
// Flow table for deauthentication / disassociation frames.
// Input channel s_valid/s_ready/s_data carries one captured frame per transfer;
// output channel m_valid/m_ready/m_data returns exactly one result per frame.
// Frames that are not management deauth/disassoc of at least 26 bytes give
// an "ignored" result in the cycle after acceptance.
// A kept frame walks the valid entries through one shared key and timestamp
// comparator, one entry per cycle out of the table RAM (registered read),
// stopping early on a match. The scan is followed by ST_WRITE, which writes
// the updated or new entry and registers the result, and then by ST_OUT.
// One frame is in flight at a time: s_ready is high only while idle, so a new
// frame is taken only after the last result is transferred. If the receiver
// holds m_ready low, the result stays on m_data and no new frame is taken
// until it is transferred.
// Reset empties the table (fill count to zero); entry contents are only read
// below the fill count, so no clearing pass is needed.
module deauth_frame_flow_table_core import dfft_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    in_item_t         item_reg, item_next;
    logic             kind_reg, kind_next;
    logic [IDX_W-1:0] wr_slot_reg, wr_slot_next;
    logic [1:0]       wr_status_reg, wr_status_next;
    logic             wr_kind_reg, wr_kind_next;
    logic [15:0]      wr_hits_reg, wr_hits_next;
    out_item_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic [1:0]       ftype;
    logic [3:0]       fsub;
    logic             keep;
    logic             ram_we;
    entry_t           ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd_entry;
    cmp_res_t         cmp_res;
    logic [IDX_W-1:0] min_idx;

    assign ftype = s_data.ctrl_word[3:2];
    assign fsub  = s_data.ctrl_word[7:4];
    assign keep  = s_data.is_mgmt && (s_data.frame_len >= MIN_FRAME_LEN) &&
                   (ftype == FTYPE_MGMT) && ((fsub == SUB_DEAUTH) || (fsub == SUB_DISASSOC));

    assign rd_entry = entry_t'(ram_rdata);

    assign ram_wdata.src    = item_reg.src_addr;
    assign ram_wdata.dst    = item_reg.dest_addr;
    assign ram_wdata.chan   = item_reg.channel;
    assign ram_wdata.kind   = wr_kind_reg;
    assign ram_wdata.reason = item_reg.reason_byte;
    assign ram_wdata.seen   = item_reg.now_ms;
    assign ram_wdata.hits   = wr_hits_reg;
    assign ram_we           = (state_reg == ST_WRITE);

    dfft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_slot_reg),
        .wr_data (ram_wdata),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    dfft_cmp #(
        .IDX_W (IDX_W)
    ) u_cmp (
        .aclk      (aclk),
        .cmp_valid (pend_reg && (state_reg == ST_SCAN)),
        .cmp_idx   (pend_idx_reg),
        .entry     (rd_entry),
        .key       (item_reg),
        .res       (cmp_res),
        .min_idx   (min_idx)
    );

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        item_next      = item_reg;
        kind_next      = kind_reg;
        wr_slot_next   = wr_slot_reg;
        wr_status_next = wr_status_reg;
        wr_kind_next   = wr_kind_reg;
        wr_hits_next   = wr_hits_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    kind_next  = (fsub == SUB_DISASSOC) ? KIND_DISASSOC : KIND_DEAUTH;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    if (keep) begin
                        state_next = ST_SCAN;
                    end else begin
                        out_next.status       = STATUS_IGNORED;
                        out_next.slot         = '0;
                        out_next.frame_kind   = KIND_DEAUTH;
                        out_next.hit_count    = '0;
                        out_next.entries_used = 6'(used_reg);
                        m_valid_next          = 1'b1;
                        state_next            = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg < used_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (cmp_res.match) begin
                    wr_slot_next   = pend_idx_reg;
                    wr_status_next = STATUS_UPDATED;
                    wr_kind_next   = cmp_res.kind;
                    wr_hits_next   = (cmp_res.hits == HITS_MAX) ? HITS_MAX
                                                                : cmp_res.hits + 1'b1;
                    pend_next      = 1'b0;
                    state_next     = ST_WRITE;
                end else if (!pend_reg && (issue_reg >= used_reg)) begin
                    if (used_reg == CNT_W'(TABLE_DEPTH)) begin
                        wr_slot_next   = min_idx;
                        wr_status_next = STATUS_REPLACED;
                    end else begin
                        wr_slot_next   = used_reg[IDX_W-1:0];
                        wr_status_next = STATUS_NEW;
                    end
                    wr_kind_next = kind_reg;
                    wr_hits_next = HITS_FIRST;
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (wr_status_reg == STATUS_NEW) begin
                    used_next = used_reg + 1'b1;
                end
                out_next.status       = wr_status_reg;
                out_next.slot         = 5'(wr_slot_reg);
                out_next.frame_kind   = kind_reg;
                out_next.hit_count    = wr_hits_reg;
                out_next.entries_used = 6'(used_next);
                m_valid_next          = 1'b1;
                state_next            = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
                pend_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        item_reg      <= item_next;
        kind_reg      <= kind_next;
        wr_slot_reg   <= wr_slot_next;
        wr_status_reg <= wr_status_next;
        wr_kind_reg   <= wr_kind_next;
        wr_hits_reg   <= wr_hits_next;
        out_reg       <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### hdl/dfft_checker.sv
`include "deauth_frame_flow_table_core_macros.svh"

module dfft_checker import dfft_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `DFFT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    `DFFT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready stayed high after a transfer")

    `DFFT_ASSERT_SAME(a_no_overlap, m_valid, !s_ready, "input taken while a result is pending")

    `DFFT_ASSERT_SAME(a_ignored_zero, m_valid && (m_data.status == STATUS_IGNORED), (m_data.slot == '0) && (m_data.hit_count == '0) && (m_data.frame_kind == KIND_DEAUTH), "ignored result carries nonzero fields")

    `DFFT_ASSERT_SAME(a_fill_first_hit, m_valid && ((m_data.status == STATUS_NEW) || (m_data.status == STATUS_REPLACED)), (m_data.hit_count == HITS_FIRST) && (m_data.entries_used != '0), "new entry must start at one hit")

endmodule

bind deauth_frame_flow_table_core dfft_checker u_dfft_checker (.*);

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dfft_pkg::*;

    localparam int          DEPTH         = 32;
    localparam int          POOL_KEYS     = 48;
    localparam int          RANDOM_FRAMES = 1480;
    localparam int          BURST_FRAMES  = 120;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = DEPTH + 8;
    localparam longint      CYCLE_LIMIT   = 400_000;
    localparam logic [47:0] ONES          = '1;

    typedef struct {
        in_item_t  frame;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    bit        row_typed = 1'b0;
    out_item_t row_want = '0;
    bit        steady = 1'b0;
    bit        pressure_armed = 1'b0;

    entry_t          flows[DEPTH];
    int unsigned     flow_count = 0;
    out_item_t       pending_results[$];
    int unsigned     status_tally[4];
    int unsigned     saturated_hits = 0;
    int unsigned     frames_in = 0;
    int unsigned     results_out = 0;
    int unsigned     mismatches = 0;
    longint unsigned cycles = 0;

    logic [47:0] pool_src[POOL_KEYS];
    logic [47:0] pool_dst[POOL_KEYS];
    logic [3:0]  pool_chan[POOL_KEYS];
    logic [31:0] stamp = 32'd200;

    deauth_frame_flow_table_core #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always #4 aclk = ~aclk;

    function automatic logic [15:0] fc_word(logic [7:0] upper, logic [3:0] sub,
                                            logic [1:0] ftype, logic [1:0] low);
        return {upper, sub, ftype, low};
    endfunction

    function automatic in_item_t make_frame(logic mgmt, logic [15:0] fc, logic [11:0] len,
                                            logic [47:0] dst, logic [47:0] src,
                                            logic [7:0] reason, logic [3:0] chan,
                                            logic [31:0] now);
        return '{is_mgmt: mgmt, ctrl_word: fc, frame_len: len, dest_addr: dst,
                 src_addr: src, reason_byte: reason, channel: chan, now_ms: now};
    endfunction

    function automatic out_item_t make_result(logic [1:0] st, logic [4:0] idx, logic kind,
                                              logic [15:0] hits, logic [5:0] used);
        return '{status: st, slot: idx, frame_kind: kind, hit_count: hits,
                 entries_used: used};
    endfunction

    // Table lookup, saturating count, fill-then-evict-oldest (lowest index on ties).
    function automatic out_item_t track_frame(in_item_t f);
        out_item_t  r;
        logic [3:0] sub;
        int         victim;
        r = '0;
        sub = f.ctrl_word[7:4];
        r.entries_used = 6'(flow_count);
        if (!f.is_mgmt || f.frame_len < MIN_FRAME_LEN || f.ctrl_word[3:2] != FTYPE_MGMT ||
            (sub != SUB_DEAUTH && sub != SUB_DISASSOC)) begin
            r.status = STATUS_IGNORED;
            return r;
        end
        r.frame_kind = (sub == SUB_DEAUTH) ? KIND_DEAUTH : KIND_DISASSOC;
        for (int i = 0; i < flow_count; i++) begin
            if (flows[i].src == f.src_addr && flows[i].dst == f.dest_addr &&
                flows[i].chan == f.channel) begin
                if (flows[i].hits != HITS_MAX)
                    flows[i].hits = flows[i].hits + 16'd1;
                else
                    saturated_hits++;
                flows[i].seen = f.now_ms;
                flows[i].reason = f.reason_byte;
                r.status = STATUS_UPDATED;
                r.slot = 5'(i);
                r.hit_count = flows[i].hits;
                return r;
            end
        end
        if (flow_count >= DEPTH) begin
            victim = 0;
            for (int i = 1; i < DEPTH; i++)
                if (flows[i].seen < flows[victim].seen)
                    victim = i;
            r.status = STATUS_REPLACED;
        end else begin
            victim = flow_count;
            flow_count++;
            r.status = STATUS_NEW;
        end
        flows[victim] = '{src: f.src_addr, dst: f.dest_addr, chan: f.channel,
                          kind: r.frame_kind, reason: f.reason_byte, seen: f.now_ms,
                          hits: HITS_FIRST};
        r.slot = 5'(victim);
        r.hit_count = HITS_FIRST;
        r.entries_used = 6'(flow_count);
        return r;
    endfunction

    task automatic check_result(out_item_t got);
        out_item_t want;
        results_out++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing outstanding: %p", results_out, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.frame_kind !== want.frame_kind || got.hit_count !== want.hit_count ||
            got.entries_used !== want.entries_used) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result %0d: expected status=%0d slot=%0d kind=%0d hits=%0d ",
                          "used=%0d, got status=%0d slot=%0d kind=%0d hits=%0d used=%0d"},
                         results_out, want.status, want.slot, want.frame_kind,
                         want.hit_count, want.entries_used, got.status, got.slot,
                         got.frame_kind, got.hit_count, got.entries_used);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t predicted;
        if (aresetn) begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (s_valid && s_ready) begin
                predicted = track_frame(s_data);
                status_tally[predicted.status]++;
                frames_in++;
                pending_results.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        int unsigned held;
        held = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (pressure_armed && held < HOLD_CYCLES) begin
                m_ready <= 1'b0;
                held++;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_frame(in_item_t f, bit typed = 1'b0, out_item_t want = '0);
        if (!steady)
            while ($urandom_range(0, 99) < 23) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        s_valid <= 1'b1;
        s_data <= f;
        row_typed <= typed;
        row_want <= want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    function automatic in_item_t random_frame();
        in_item_t     f;
        int unsigned  pick;
        int unsigned  k;
        logic [3:0]   sub;
        logic [191:0] noise;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, POOL_KEYS - 1);
        sub = $urandom_range(0, 1) ? SUB_DEAUTH : SUB_DISASSOC;
        stamp += $urandom_range(0, 3);
        f = make_frame(1'b1, fc_word(8'($urandom), sub, FTYPE_MGMT, 2'($urandom)),
                       ($urandom_range(0, 7) == 0) ? MIN_FRAME_LEN
                                                   : 12'($urandom_range(26, 4095)),
                       pool_dst[k], pool_src[k], 8'($urandom), pool_chan[k],
                       ($urandom_range(0, 9) == 0) ? 32'($urandom) : stamp);
        if (pick >= 70 && pick < 76) begin
            f.src_addr = 48'({$urandom, $urandom});
            f.dest_addr = 48'({$urandom, $urandom});
            f.channel = 4'($urandom);
        end else if (pick >= 76 && pick < 90) begin
            case ($urandom_range(0, 3))
                0: f.is_mgmt = 1'b0;
                1: f.frame_len = 12'($urandom_range(0, 25));
                2: f.ctrl_word[3:2] = 2'($urandom_range(1, 3));
                default: begin
                    sub = 4'($urandom);
                    if (sub == SUB_DEAUTH || sub == SUB_DISASSOC)
                        sub ^= 4'h1;
                    f.ctrl_word[7:4] = sub;
                end
            endcase
        end else if (pick >= 90) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            f = noise[$bits(in_item_t)-1:0];
        end
        return f;
    endfunction

    initial begin : stimulus
        stim_row_t   rows[$];
        logic [15:0] fc_deauth;
        logic [15:0] fc_disassoc;
        int unsigned n;

        fc_deauth = fc_word(8'h00, SUB_DEAUTH, FTYPE_MGMT, 2'b00);
        fc_disassoc = fc_word(8'h00, SUB_DISASSOC, FTYPE_MGMT, 2'b00);
        for (int k = 0; k < POOL_KEYS; k++) begin
            // groups of three keys share the source, pairs share the destination too
            pool_src[k] = (k % 3 != 0) ? pool_src[k-1] : 48'({$urandom, $urandom});
            pool_dst[k] = (k % 3 == 2) ? pool_dst[k-1] : 48'({$urandom, $urandom});
            pool_chan[k] = 4'($urandom);
        end

        rows.push_back('{make_frame(1'b0, fc_deauth, MIN_FRAME_LEN, '0, ONES, 8'h00, 4'd15,
                                    32'd0), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd0)});
        rows.push_back('{make_frame(1'b1, fc_word(8'h00, SUB_DEAUTH, ~FTYPE_MGMT, 2'b00),
                                    MIN_FRAME_LEN, '0, ONES, 8'h00, 4'd15, 32'd0), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd0)});
        rows.push_back('{make_frame(1'b1, fc_deauth, MIN_FRAME_LEN - 12'd1, '0, ONES, 8'h00,
                                    4'd15, 32'd0), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd0)});
        rows.push_back('{make_frame(1'b1, fc_word(8'h00, SUB_DEAUTH ^ 4'h1, FTYPE_MGMT, 2'b00),
                                    MIN_FRAME_LEN, '0, ONES, 8'h00, 4'd15, 32'd0), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd0)});
        rows.push_back('{make_frame(1'b1, fc_deauth, MIN_FRAME_LEN, '0, ONES, 8'h00, 4'd15,
                                    32'd0), 1'b1,
                         make_result(STATUS_NEW, 5'd0, KIND_DEAUTH, 16'd1, 6'd1)});
        rows.push_back('{make_frame(1'b1, fc_disassoc, 12'd4095, '0, ONES, 8'h55, 4'd15,
                                    32'd7), 1'b1,
                         make_result(STATUS_UPDATED, 5'd0, KIND_DISASSOC, 16'd2, 6'd1)});
        rows.push_back('{make_frame(1'b1, fc_deauth, 12'd100, '0, ONES, 8'h01, 4'd0,
                                    32'd7), 1'b1,
                         make_result(STATUS_NEW, 5'd1, KIND_DEAUTH, 16'd1, 6'd2)});
        rows.push_back('{make_frame(1'b1, fc_word(8'hFF, SUB_DEAUTH, FTYPE_MGMT, 2'b11),
                                    12'd26, ONES, '0, 8'hFF, 4'd14, 32'hFFFF_FFFF), 1'b1,
                         make_result(STATUS_NEW, 5'd2, KIND_DEAUTH, 16'd1, 6'd3)});
        rows.push_back('{make_frame(1'b1, fc_word(8'hFF, SUB_DISASSOC, FTYPE_MGMT, 2'b11),
                                    12'd26, 48'hBA98_7654_3210, 48'h0123_4567_89AB, 8'h07,
                                    4'd1, 32'd7), 1'b1,
                         make_result(STATUS_NEW, 5'd3, KIND_DISASSOC, 16'd1, 6'd4)});
        rows.push_back('{make_frame(1'b1, 16'hFFFF, 12'd4095, 48'hBA98_7654_3210,
                                    48'h0123_4567_89AB, 8'h07, 4'd1, 32'd7), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd4)});
        rows.push_back('{make_frame(1'b0, fc_deauth, 12'd4095, ONES, '0, 8'hFF, 4'd14,
                                    32'd9), 1'b1,
                         make_result(STATUS_IGNORED, 5'd0, KIND_DEAUTH, 16'd0, 6'd4)});
        rows.push_back('{make_frame(1'b1, fc_disassoc, 12'd64, ONES, '0, 8'h33, 4'd14,
                                    32'hFFFF_FFFF), 1'b1,
                         make_result(STATUS_UPDATED, 5'd2, KIND_DISASSOC, 16'd2, 6'd4)});
        rows.push_back('{make_frame(1'b1, fc_deauth, 12'd64, ONES, ONES, 8'h44, 4'd15,
                                    32'd7), 1'b1,
                         make_result(STATUS_NEW, 5'd4, KIND_DEAUTH, 16'd1, 6'd5)});
        // same addresses as slot 0, other channel
        rows.push_back('{make_frame(1'b1, fc_deauth, 12'd64, '0, ONES, 8'h45, 4'd14,
                                    32'd7), 1'b0, '0});

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            send_frame(rows[i].frame, rows[i].typed, rows[i].want);

        // back-to-back hits on slot 0 with no idling on either side
        steady = 1'b1;
        for (int i = 0; i < BURST_FRAMES; i++)
            send_frame(make_frame(1'b1, fc_word(8'($urandom),
                                                $urandom_range(0, 1) ? SUB_DEAUTH
                                                                     : SUB_DISASSOC,
                                                FTYPE_MGMT, 2'($urandom)),
                                  12'd26 + 12'($urandom_range(0, 100)), '0, ONES,
                                  8'($urandom), 4'd15, 32'd7));
        steady = 1'b0;

        // fill with equal timestamps, then misses evict the oldest entries, lowest index first
        while (flow_count < DEPTH)
            send_frame(make_frame(1'b1, fc_deauth, 12'd64, 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), 8'($urandom), 4'($urandom),
                                  32'd7));
        for (int i = 0; i < 6; i++)
            send_frame(make_frame(1'b1, fc_disassoc, 12'd64, 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), 8'($urandom), 4'($urandom),
                                  32'd100));

        n = 0;
        while (n < RANDOM_FRAMES) begin
            if (n == 200)
                pressure_armed = 1'b1;
            send_frame(random_frame());
            n++;
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display({"%0d frames: %0d ignored, %0d hits (%0d at the count ceiling), ",
                  "%0d fills, %0d evictions"},
                 frames_in, status_tally[STATUS_IGNORED], status_tally[STATUS_UPDATED],
                 saturated_hits, status_tally[STATUS_NEW], status_tally[STATUS_REPLACED]);
        $display("%0d results checked, %0d mismatches, %0d cycles", results_out, mismatches,
                 cycles);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dfft_pkg.sv
hdl/dfft_ram.sv
hdl/dfft_cmp.sv
hdl/deauth_frame_flow_table_core.sv
hdl/dfft_checker.sv
tb/testbench.sv
